// File: sv/qfst_pkg.sv
// Shared types and constants for the quartic form square test.
// Used by qfst_poly, qfst_sqrt_cell and quartic_form_square_test.
package qfst_pkg;

    localparam int COORD_BOUND_DEF  = 4095;
    localparam int MEMBER_BOUND_DEF = 65535;

    localparam int WIDE_W    = 128;
    localparam int ROOT_W    = WIDE_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int NUM_LANES = 4;

    typedef logic signed [WIDE_W-1:0] wide_t;

    // One value on its way through the square root chain.
    typedef struct packed {
        logic [WIDE_W-1:0] x;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic              pos;
    } lane_t;

    typedef lane_t [NUM_LANES-1:0] lanes_t;

endpackage

// File: sv/qfst_poly.sv
// Pipelined evaluation of the four polynomial values X1..X4.
// Depends on qfst_pkg; nine register stages, all advancing on en.
module qfst_poly #(
    parameter int COORD_BOUND  = qfst_pkg::COORD_BOUND_DEF,
    parameter int MEMBER_BOUND = qfst_pkg::MEMBER_BOUND_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [12:0]       num_p,
    input  logic        [11:0]       den_q,
    input  logic signed [16:0]       member_num,
    input  logic        [15:0]       member_den,
    output logic                     out_valid,
    output qfst_pkg::wide_t          x_out [qfst_pkg::NUM_LANES]
);
    import qfst_pkg::*;

    localparam int NSTAGE = 9;
    localparam int NTERM  = 11;
    localparam int NPART  = 4;
    localparam int PART_W = 32;

    // Positions of the coefficient-monomial terms.
    localparam int T_QN2  = 0;
    localparam int T_ANR  = 1;
    localparam int T_BNR  = 2;
    localparam int T_AR2  = 3;
    localparam int T_C3N3 = 4;
    localparam int T_C2   = 5;
    localparam int T_C1   = 6;
    localparam int T_C0   = 7;
    localparam int T_C3N2 = 8;
    localparam int T_D4   = 9;
    localparam int T_E4   = 10;

    logic [NSTAGE-1:0] vld_reg, vld_next;

    // Stage 0: clamped inputs.
    logic signed [12:0] p0_reg, p0_next;
    logic signed [12:0] q0_reg, q0_next;
    logic signed [17:0] rn0_reg, rn0_next;
    logic signed [17:0] rd0_reg, rd0_next;

    // Stage 1: second-degree products.
    logic signed [26:0] p2_1_reg, pq_1_reg, q2_1_reg;
    logic signed [35:0] n2_1_reg, nr_1_reg, r2_1_reg;
    logic signed [17:0] rn1_reg, rd1_reg;

    // Stage 2: fourth-degree products in p, q and third degree in rn, rd.
    logic signed [54:0] p4_2_reg, p3q_2_reg, p2q2_2_reg, pq3_2_reg, q4_2_reg;
    logic signed [26:0] p2_2_reg, pq_2_reg, q2_2_reg;
    logic signed [54:0] n3_2_reg, n2r_2_reg, nr2_2_reg, r3_2_reg;
    logic signed [35:0] n2_2_reg, nr_2_reg, r2_2_reg;
    logic signed [17:0] rn2_reg;

    // Stage 3: coefficients.
    logic signed [61:0] qq_reg, a1_reg, b2_reg, c3_reg, c2_reg, c1_reg, c0_reg;
    logic signed [61:0] d4_reg, e4_reg;
    logic signed [54:0] n3_3_reg, n2r_3_reg, nr2_3_reg, r3_3_reg;
    logic signed [35:0] n2_3_reg, nr_3_reg, r2_3_reg;
    logic signed [17:0] rn3_reg;

    // Stage 4: each term is split at bit 31 into four partial products.
    logic signed [61:0] coef_sel [NTERM];
    logic signed [61:0] mono_sel [NTERM];
    logic signed [30:0] c_hi [NTERM];
    logic signed [31:0] c_lo [NTERM];
    logic signed [30:0] m_hi [NTERM];
    logic signed [31:0] m_lo [NTERM];
    logic signed [61:0] pp_hh_reg [NTERM];
    logic signed [62:0] pp_hl_reg [NTERM];
    logic signed [62:0] pp_lh_reg [NTERM];
    logic signed [63:0] pp_ll_reg [NTERM];
    logic signed [17:0] rn4_reg;

    // Stage 5: full terms; stage 6: sums.
    wide_t term_reg [NTERM];
    logic signed [17:0] rn5_reg;
    wide_t x1_6_reg, x2_6_reg, in_6_reg, x4_6_reg;
    logic signed [17:0] rn6_reg;

    // Stage 7: rn times each 32-bit slice of the inner sum; stage 8: X3.
    logic signed [32:0] inner_part [NPART];
    logic signed [50:0] x3pp_reg [NPART];
    wide_t x1_7_reg, x2_7_reg, x4_7_reg;
    wide_t x1_8_reg, x2_8_reg, x3_8_reg, x4_8_reg;

    logic signed [31:0] pv, qv, nv, dv;

    always_comb
    begin
        pv = 32'(num_p);
        qv = 32'({1'b0, den_q});
        nv = 32'(member_num);
        dv = 32'({1'b0, member_den});
        if (pv > COORD_BOUND)
            pv = COORD_BOUND;
        else if (pv < -COORD_BOUND)
            pv = -COORD_BOUND;
        if (qv > COORD_BOUND)
            qv = COORD_BOUND;
        if (nv > MEMBER_BOUND)
            nv = MEMBER_BOUND;
        else if (nv < -MEMBER_BOUND)
            nv = -MEMBER_BOUND;
        if (dv > MEMBER_BOUND)
            dv = MEMBER_BOUND;
        p0_next  = 13'(pv);
        q0_next  = 13'(qv);
        rn0_next = 18'(nv);
        rd0_next = 18'(dv);
        vld_next = {vld_reg[NSTAGE-2:0], in_valid};
    end

    always_comb
    begin
        coef_sel[T_QN2]  = qq_reg;
        mono_sel[T_QN2]  = 62'(n2_3_reg);
        coef_sel[T_ANR]  = a1_reg;
        mono_sel[T_ANR]  = 62'(nr_3_reg);
        coef_sel[T_BNR]  = b2_reg;
        mono_sel[T_BNR]  = 62'(nr_3_reg);
        coef_sel[T_AR2]  = a1_reg;
        mono_sel[T_AR2]  = 62'(r2_3_reg);
        coef_sel[T_C3N3] = c3_reg;
        mono_sel[T_C3N3] = 62'(n3_3_reg);
        coef_sel[T_C2]   = c2_reg;
        mono_sel[T_C2]   = 62'(n2r_3_reg);
        coef_sel[T_C1]   = c1_reg;
        mono_sel[T_C1]   = 62'(nr2_3_reg);
        coef_sel[T_C0]   = c0_reg;
        mono_sel[T_C0]   = 62'(r3_3_reg);
        coef_sel[T_C3N2] = c3_reg;
        mono_sel[T_C3N2] = 62'(n2_3_reg);
        coef_sel[T_D4]   = d4_reg;
        mono_sel[T_D4]   = 62'(nr_3_reg);
        coef_sel[T_E4]   = e4_reg;
        mono_sel[T_E4]   = 62'(r2_3_reg);
        // The high half keeps the sign; the low half is a plain magnitude.
        for (int k = 0; k < NTERM; k++)
        begin
            c_hi[k] = coef_sel[k][61:31];
            c_lo[k] = $signed({1'b0, coef_sel[k][30:0]});
            m_hi[k] = mono_sel[k][61:31];
            m_lo[k] = $signed({1'b0, mono_sel[k][30:0]});
        end
        for (int k = 0; k < NPART - 1; k++)
            inner_part[k] = $signed({1'b0, in_6_reg[PART_W*k +: PART_W]});
        inner_part[NPART-1] = 33'($signed(in_6_reg[WIDE_W-1 -: PART_W]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            q0_reg  <= q0_next;
            rn0_reg <= rn0_next;
            rd0_reg <= rd0_next;

            p2_1_reg <= 27'(p0_reg * p0_reg);
            pq_1_reg <= 27'(p0_reg * q0_reg);
            q2_1_reg <= 27'(q0_reg * q0_reg);
            n2_1_reg <= 36'(rn0_reg * rn0_reg);
            nr_1_reg <= 36'(rn0_reg * rd0_reg);
            r2_1_reg <= 36'(rd0_reg * rd0_reg);
            rn1_reg  <= rn0_reg;
            rd1_reg  <= rd0_reg;

            p4_2_reg   <= 55'(p2_1_reg * p2_1_reg);
            p3q_2_reg  <= 55'(p2_1_reg * pq_1_reg);
            p2q2_2_reg <= 55'(p2_1_reg * q2_1_reg);
            pq3_2_reg  <= 55'(pq_1_reg * q2_1_reg);
            q4_2_reg   <= 55'(q2_1_reg * q2_1_reg);
            p2_2_reg   <= p2_1_reg;
            pq_2_reg   <= pq_1_reg;
            q2_2_reg   <= q2_1_reg;
            n3_2_reg   <= 55'(n2_1_reg * rn1_reg);
            n2r_2_reg  <= 55'(n2_1_reg * rd1_reg);
            nr2_2_reg  <= 55'(nr_1_reg * rd1_reg);
            r3_2_reg   <= 55'(r2_1_reg * rd1_reg);
            n2_2_reg   <= n2_1_reg;
            nr_2_reg   <= nr_1_reg;
            r2_2_reg   <= r2_1_reg;
            rn2_reg    <= rn1_reg;

            qq_reg <= 62'(62'(p2_2_reg) * 4 - 62'(pq_2_reg) * 6 + 62'(q2_2_reg) * 3);
            a1_reg <= 62'(62'(pq_2_reg) * 2 - 62'(q2_2_reg));
            b2_reg <= 62'(62'(p2_2_reg) * 4 - 62'(pq_2_reg) * 4 + 62'(q2_2_reg) * 2);
            c3_reg <= 62'(62'(p4_2_reg) * 16 - 62'(p3q_2_reg) * 40
                        + 62'(p2q2_2_reg) * 40 - 62'(pq3_2_reg) * 18 + 62'(q4_2_reg) * 3);
            c2_reg <= 62'(-62'(p4_2_reg) * 16 + 62'(p3q_2_reg) * 32
                        - 62'(p2q2_2_reg) * 28 + 62'(pq3_2_reg) * 10 - 62'(q4_2_reg));
            c1_reg <= 62'(62'(p3q_2_reg) * 8 - 62'(p2q2_2_reg) * 12
                        + 62'(pq3_2_reg) * 10 - 62'(q4_2_reg) * 3);
            c0_reg <= 62'(62'(q4_2_reg) - 62'(pq3_2_reg) * 2);
            d4_reg <= 62'(-62'(p3q_2_reg) * 16 + 62'(p2q2_2_reg) * 28
                        - 62'(pq3_2_reg) * 18 + 62'(q4_2_reg) * 4);
            e4_reg <= 62'(62'(p2q2_2_reg) * 4 - 62'(pq3_2_reg) * 4 + 62'(q4_2_reg));
            n3_3_reg  <= n3_2_reg;
            n2r_3_reg <= n2r_2_reg;
            nr2_3_reg <= nr2_2_reg;
            r3_3_reg  <= r3_2_reg;
            n2_3_reg  <= n2_2_reg;
            nr_3_reg  <= nr_2_reg;
            r2_3_reg  <= r2_2_reg;
            rn3_reg   <= rn2_reg;

            for (int k = 0; k < NTERM; k++)
            begin
                pp_hh_reg[k] <= 62'(c_hi[k] * m_hi[k]);
                pp_hl_reg[k] <= 63'(c_hi[k] * m_lo[k]);
                pp_lh_reg[k] <= 63'(c_lo[k] * m_hi[k]);
                pp_ll_reg[k] <= 64'(c_lo[k] * m_lo[k]);
            end
            rn4_reg <= rn3_reg;

            for (int k = 0; k < NTERM; k++)
                term_reg[k] <= (wide_t'(pp_hh_reg[k]) << 62)
                               + (wide_t'(pp_hl_reg[k]) << 31)
                               + (wide_t'(pp_lh_reg[k]) << 31)
                               + wide_t'(pp_ll_reg[k]);
            rn5_reg <= rn4_reg;

            x1_6_reg <= term_reg[T_QN2] - term_reg[T_ANR];
            x2_6_reg <= term_reg[T_QN2] - term_reg[T_BNR] + term_reg[T_AR2];
            in_6_reg <= term_reg[T_C3N3] + term_reg[T_C2] + term_reg[T_C1] + term_reg[T_C0];
            x4_6_reg <= term_reg[T_C3N2] + term_reg[T_D4] + term_reg[T_E4];
            rn6_reg  <= rn5_reg;

            for (int k = 0; k < NPART; k++)
                x3pp_reg[k] <= 51'(rn6_reg * inner_part[k]);
            x1_7_reg <= x1_6_reg;
            x2_7_reg <= x2_6_reg;
            x4_7_reg <= x4_6_reg;

            x1_8_reg <= x1_7_reg;
            x2_8_reg <= x2_7_reg;
            x3_8_reg <= wide_t'(x3pp_reg[0]) + (wide_t'(x3pp_reg[1]) << PART_W)
                        + (wide_t'(x3pp_reg[2]) << (2 * PART_W))
                        + (wide_t'(x3pp_reg[3]) << (3 * PART_W));
            x4_8_reg <= x4_7_reg;
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign x_out[0]  = x1_8_reg;
    assign x_out[1]  = x2_8_reg;
    assign x_out[2]  = x3_8_reg;
    assign x_out[3]  = x4_8_reg;

endmodule

// File: sv/qfst_sqrt_cell.sv
// One cell of the square root chain: settles one root bit for every lane.
// Depends on qfst_pkg.
module qfst_sqrt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  qfst_pkg::lanes_t in_lanes,
    output logic             out_valid,
    output qfst_pkg::lanes_t out_lanes
);
    import qfst_pkg::*;

    logic   valid_reg;
    lanes_t lanes_reg, lanes_next;

    logic [REM_W-1:0] rem_w [NUM_LANES];
    logic [REM_W-1:0] trial [NUM_LANES];

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            // Bring down the next two bits and try appending a one to the root.
            rem_w[i] = {in_lanes[i].rem[REM_W-3:0], in_lanes[i].x[WIDE_W-1 -: 2]};
            trial[i] = REM_W'({in_lanes[i].root, 2'b01});
            lanes_next[i].pos = in_lanes[i].pos;
            lanes_next[i].x   = {in_lanes[i].x[WIDE_W-3:0], 2'b00};
            if (rem_w[i] >= trial[i])
            begin
                lanes_next[i].rem  = rem_w[i] - trial[i];
                lanes_next[i].root = {in_lanes[i].root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                lanes_next[i].rem  = rem_w[i];
                lanes_next[i].root = {in_lanes[i].root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lanes_reg <= lanes_next;
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

endmodule

// File: sv/quartic_form_square_test.sv
// Top level of the quartic form square test.
// Depends on qfst_pkg, qfst_poly and qfst_sqrt_cell.
//
// Usage:
//   The item channel (item_valid, item_stall) takes one candidate point per
//   beat: num_p, den_q, member_num, member_den. The result channel
//   (result_valid, result_stall) gives one beat per item: square_mask,
//   near_hit and full_hit, in the order the items came in.
//   A result beat passes through nine stages that form the four polynomial
//   values, a chain of 64 cells that settles one root bit each for all four
//   values, and one output register that holds the result beat.
//   Throughput is one item per cycle while result_stall does not hold the
//   pipeline; every stage and every cell passes its work on while not held.
//   While a result waits with result_stall high, the whole pipeline holds and
//   item_stall is raised; it drops in the cycle the result is taken.
//   Reset clears every valid bit, so no result beat appears until items
//   arrive. Values out of bounds are clamped before evaluation.
module quartic_form_square_test #(
    parameter int COORD_BOUND  = qfst_pkg::COORD_BOUND_DEF,
    parameter int MEMBER_BOUND = qfst_pkg::MEMBER_BOUND_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [12:0] num_p,
    input  logic        [11:0] den_q,
    input  logic signed [16:0] member_num,
    input  logic        [15:0] member_den,
    output logic               result_valid,
    input  logic               result_stall,
    output logic        [3:0]  square_mask,
    output logic               near_hit,
    output logic               full_hit
);
    import qfst_pkg::*;

    logic  adv;
    logic  poly_valid;
    wide_t poly_x [NUM_LANES];

    logic   chain_valid [ROOT_W+1];
    lanes_t chain_lanes [ROOT_W+1];

    logic       valid_reg;
    logic [3:0] mask_reg, mask_next;

    assign adv        = !(valid_reg && result_stall);
    assign item_stall = !adv;

    qfst_poly #(
        .COORD_BOUND  (COORD_BOUND),
        .MEMBER_BOUND (MEMBER_BOUND)
    ) u_poly (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (item_valid),
        .num_p      (num_p),
        .den_q      (den_q),
        .member_num (member_num),
        .member_den (member_den),
        .out_valid  (poly_valid),
        .x_out      (poly_x)
    );

    always_comb
    begin
        chain_valid[0] = poly_valid;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            chain_lanes[0][i].x    = poly_x[i];
            chain_lanes[0][i].rem  = '0;
            chain_lanes[0][i].root = '0;
            chain_lanes[0][i].pos  = !poly_x[i][WIDE_W-1] && (|poly_x[i]);
        end
    end

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_cell
        qfst_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (chain_valid[g]),
            .in_lanes  (chain_lanes[g]),
            .out_valid (chain_valid[g+1]),
            .out_lanes (chain_lanes[g+1])
        );
    end

    // A value is a square when it was positive and the remainder ran out.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
            mask_next[i] = chain_lanes[ROOT_W][i].pos && (chain_lanes[ROOT_W][i].rem == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= chain_valid[ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            mask_reg <= mask_next;
    end

    assign result_valid = valid_reg;
    assign square_mask  = mask_reg;
    assign near_hit     = &mask_reg[2:0];
    assign full_hit     = &mask_reg;

    a_full_implies_near: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && full_hit) |-> near_hit)
        else $error("full hit without near hit");

    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall))
        else $error("item stall does not match the held result");

    a_held_result_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(square_mask)))
        else $error("held result changed");

endmodule

// File: bench/quartic_form_square_test_tb.sv
// Testbench for quartic_form_square_test: drives candidate points and checks
// every result beat against a predictor built on 128-bit signed arithmetic.
// Depends on qfst_pkg and the quartic_form_square_test RTL.
module quartic_form_square_test_tb;

    import qfst_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_PER_PHASE = 333;

    typedef struct {
        logic [3:0] mask;
        logic       near;
        logic       full;
    } verdict_t;

    // Holds predicted verdicts in arrival order and compares result beats.
    class verdict_board;
        verdict_t pending[$];

        static function automatic bit is_positive_square(wide_t x);
            logic [127:0] ux;
            logic [127:0] sq;
            logic [63:0]  root;
            logic [63:0]  cand;
            if (x <= 0)
                return 1'b0;
            ux = x;
            root = '0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = root | (64'd1 << b);
                sq = {64'd0, cand} * {64'd0, cand};
                if (sq <= ux)
                    root = cand;
            end
            sq = {64'd0, root} * {64'd0, root};
            return sq == ux;
        endfunction

        function void note(logic signed [12:0] np, logic [11:0] dq,
                           logic signed [16:0] mn, logic [15:0] md);
            wide_t p, q, rn, rd, p2, p3, p4, q2, q3, q4, tq, qq, a1, b2;
            wide_t c3, c2, c1, c0, d4, e4, x1, x2, x3, x4;
            verdict_t v;
            p = np;
            q = dq;
            rn = mn;
            rd = md;
            if (p > COORD_BOUND_DEF) p = COORD_BOUND_DEF;
            if (p < -COORD_BOUND_DEF) p = -COORD_BOUND_DEF;
            if (q > COORD_BOUND_DEF) q = COORD_BOUND_DEF;
            if (rn > MEMBER_BOUND_DEF) rn = MEMBER_BOUND_DEF;
            if (rn < -MEMBER_BOUND_DEF) rn = -MEMBER_BOUND_DEF;
            if (rd > MEMBER_BOUND_DEF) rd = MEMBER_BOUND_DEF;
            p2 = p * p;
            p3 = p2 * p;
            p4 = p3 * p;
            q2 = q * q;
            q3 = q2 * q;
            q4 = q3 * q;
            tq = 2 * p - q;
            qq = 4 * p2 - 6 * p * q + 3 * q2;
            a1 = tq * q;
            b2 = 4 * p2 - 4 * p * q + 2 * q2;
            c3 = 16 * p4 - 40 * p3 * q + 40 * p2 * q2 - 18 * p * q3 + 3 * q4;
            c2 = -16 * p4 + 32 * p3 * q - 28 * p2 * q2 + 10 * p * q3 - q4;
            c1 = (8 * p3 - 12 * p2 * q + 10 * p * q2 - 3 * q3) * q;
            c0 = -tq * q3;
            d4 = (-16 * p3 + 28 * p2 * q - 18 * p * q2 + 4 * q3) * q;
            e4 = tq * tq * q2;
            x1 = qq * rn * rn - a1 * rn * rd;
            x2 = qq * rn * rn - b2 * rn * rd + a1 * rd * rd;
            x3 = rn * (c3 * rn * rn * rn + c2 * rn * rn * rd
                       + c1 * rn * rd * rd + c0 * rd * rd * rd);
            x4 = c3 * rn * rn + d4 * rn * rd + e4 * rd * rd;
            v.mask = {is_positive_square(x4), is_positive_square(x3),
                      is_positive_square(x2), is_positive_square(x1)};
            v.near = &v.mask[2:0];
            v.full = &v.mask;
            pending.push_back(v);
        endfunction

        // Returns an empty string when the beat matches.
        function string check(logic [3:0] mask, logic near, logic full);
            verdict_t v;
            if (pending.size() == 0)
                return "result beat with nothing expected";
            v = pending.pop_front();
            if (mask !== v.mask || near !== v.near || full !== v.full)
                return $sformatf("got mask %h near %b full %b, want %h %b %b",
                                 mask, near, full, v.mask, v.near, v.full);
            return "";
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic signed [12:0] num_p;
    logic        [11:0] den_q;
    logic signed [16:0] member_num;
    logic        [15:0] member_den;
    logic               result_valid;
    logic               result_stall;
    logic        [3:0]  square_mask;
    logic               near_hit;
    logic               full_hit;

    verdict_board board;
    int  error_count;
    int  idle_pct;
    int  stall_pct;
    bit  hold_results;
    int  quiet_cycles;

    quartic_form_square_test u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .num_p       (num_p),
        .den_q       (den_q),
        .member_num  (member_num),
        .member_den  (member_den),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .square_mask (square_mask),
        .near_hit    (near_hit),
        .full_hit    (full_hit)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        string msg;
        if (item_valid && !item_stall)
            board.note(num_p, den_q, member_num, member_den);
        if (result_valid && !result_stall)
        begin
            msg = board.check(square_mask, near_hit, full_hit);
            if (msg != "")
                report(msg);
        end
    end

    always @(posedge clk)
    begin
        if (hold_results)
            result_stall <= 1'b1;
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("quartic_form_square_test_tb: errors");
            $finish;
        end
    end

    task automatic send_point(logic [12:0] np, logic [11:0] dq,
                              logic [16:0] mn, logic [15:0] md);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        num_p <= np;
        den_q <= dq;
        member_num <= mn;
        member_den <= md;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Small operands land on perfect squares far more often than full-range ones.
    task automatic send_random();
        if ($urandom_range(1))
            send_point($urandom, $urandom, $urandom, $urandom);
        else
            send_point($urandom_range(8) - 4, $urandom_range(6), $urandom_range(20) - 10,
                       $urandom_range(12));
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic long_hold();
        hold_results = 1'b1;
        repeat (300) @(posedge clk);
        hold_results = 1'b0;
    endtask

    initial
    begin
        board = new();
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_results = 1'b0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        result_stall = 1'b0;
        num_p = '0;
        den_q = '0;
        member_num = '0;
        member_den = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, out-of-bound codes that clamp, zero denominators,
        // zero and negative values, and a few known squares.
        send_point(0, 1, 1, 1);
        send_point(0, 1, 0, 1);
        send_point(13'h1000, 12'hfff, 17'h10000, 16'hffff);
        send_point(13'h0fff, 12'hfff, 17'h0ffff, 16'hffff);
        send_point(13'h1001, 12'hfff, 17'h10001, 16'hffff);
        send_point(13'h1fff, 1, 17'h1ffff, 1);
        send_point(5, 0, 3, 7);
        send_point(5, 3, 3, 0);
        send_point(0, 0, 0, 0);
        send_point(1, 1, 1, 1);
        send_point(1, 2, 2, 3);
        send_point(2, 1, -1, 1);
        send_point(-1, 1, 1, 2);
        send_point(0, 1, 2, 2);
        send_point(3, 2, -4, 5);
        send_point(1, 1, 4, 1);
        send_point(0, 1, -1, 3);
        send_point(13'h1000, 1, 17'h10000, 1);
        send_point(13'h0fff, 1, 17'h0ffff, 1);
        send_point(2, 3, 1, 1);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 29 : 0;
            stall_pct = (ph == 2) ? 70 : (ph == 3) ? 29 : 0;
            if (ph == 0)
                fork
                    long_hold();
                join_none
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (ph == 1 && i == RANDOM_PER_PHASE / 2)
                    wait_drained();
                send_random();
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && board.pending.size() == 0)
            $display("quartic_form_square_test_tb: clean");
        else
            $display("quartic_form_square_test_tb: errors");
        $finish;
    end

endmodule

// File: quartic_form_square_test.f
sv/qfst_pkg.sv
sv/qfst_poly.sv
sv/qfst_sqrt_cell.sv
sv/quartic_form_square_test.sv
bench/quartic_form_square_test_tb.sv
